FILE: hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion with the reset as disable condition.
`define FUMD_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("fumd check failed");

// Assertion that is also checked while reset is high.
`define FUMD_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("fumd check failed");

`endif

FILE: hw/rtl/fumd_pkg.sv
`default_nettype none

package fumd_pkg;

   // Byte that closes the list of one glyph.
   localparam logic [7:0] END_MARK   = 8'hFF;
   // Payload masks for lead and continuation bytes.
   localparam logic [7:0] MASK_TWO   = 8'h1F;
   localparam logic [7:0] MASK_THREE = 8'h0F;
   localparam logic [7:0] MASK_FOUR  = 8'h07;
   localparam logic [7:0] MASK_CONT  = 8'h3F;

   localparam int CODE_W    = 21;
   localparam int GLYPH_W   = 16;
   localparam int PENDING_W = 2;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       table_start;
      logic       last_byte;
   } req_item_type;

   typedef struct packed {
      logic [15:0] code_point;
      logic [15:0] glyph_index;
   } rsp_item_type;

   // What the decoder hands back for one processed item.
   typedef struct packed {
      logic         emit;
      rsp_item_type item;
   } dec_out_type;

endpackage

`default_nettype wire

FILE: hw/rtl/fumd_decode.sv
`default_nettype none

module fumd_decode (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  proc_en,
   input  wire fumd_pkg::req_item_type item,
   output fumd_pkg::dec_out_type      dout
);

   logic [fumd_pkg::GLYPH_W-1:0]   glyph_count_ff, glyph_count_in;
   logic [fumd_pkg::CODE_W-1:0]    partial_code_ff, partial_code_in;
   logic [fumd_pkg::PENDING_W-1:0] bytes_pending_ff, bytes_pending_in;

   logic [fumd_pkg::GLYPH_W-1:0]   g0;
   logic [fumd_pkg::CODE_W-1:0]    p0;
   logic [fumd_pkg::PENDING_W-1:0] n0;
   logic                           emit;
   logic [15:0]                    code;
   logic [7:0]                     b;

   // One byte of UTF-8 decode on top of the state left by the previous item.
   always_comb begin
      b    = item.data_byte;
      g0   = item.table_start ? '0 : glyph_count_ff;
      p0   = item.table_start ? '0 : partial_code_ff;
      n0   = item.table_start ? '0 : bytes_pending_ff;
      glyph_count_in   = g0;
      partial_code_in  = p0;
      bytes_pending_in = n0;
      emit = 1'b0;
      code = '0;

      if (n0 != '0) begin
         // Any byte counts as a continuation while a sequence is open.
         partial_code_in  = {p0[fumd_pkg::CODE_W-7:0], b[5:0] & fumd_pkg::MASK_CONT[5:0]};
         bytes_pending_in = n0 - 2'd1;
         if (bytes_pending_in == '0) begin
            emit            = 1'b1;
            code            = partial_code_in[15:0];
            partial_code_in = '0;
         end
      end else begin
         case (b) inside
            fumd_pkg::END_MARK: begin
               glyph_count_in = g0 + 16'd1;
            end
            8'b0???_????: begin
               emit = 1'b1;
               code = {8'h00, b};
            end
            8'b1?0?_????: begin
               partial_code_in  = 21'(b & fumd_pkg::MASK_TWO);
               bytes_pending_in = 2'd1;
            end
            8'b1?10_????: begin
               partial_code_in  = 21'(b & fumd_pkg::MASK_THREE);
               bytes_pending_in = 2'd2;
            end
            default: begin
               // Catch-all lead: everything else with bits 7, 5 and 4 set.
               partial_code_in  = 21'(b & fumd_pkg::MASK_FOUR);
               bytes_pending_in = 2'd3;
            end
         endcase
      end

      // An unfinished sequence does not survive the last byte of a table.
      if (item.last_byte && bytes_pending_in != '0) begin
         partial_code_in  = '0;
         bytes_pending_in = '0;
      end

      dout.emit             = emit;
      dout.item.code_point  = code;
      dout.item.glyph_index = glyph_count_in;
   end

   // Decoder state, advanced once for every processed item.
   always_ff @(posedge clock) begin
      if (reset) begin
         glyph_count_ff   <= '0;
         partial_code_ff  <= '0;
         bytes_pending_ff <= '0;
      end else if (proc_en) begin
         glyph_count_ff   <= glyph_count_in;
         partial_code_ff  <= partial_code_in;
         bytes_pending_ff <= bytes_pending_in;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/font_unicode_map_decoder_top.sv
// Decodes the unicode table of a PSF2 font one byte per item into (code point, glyph)
// pairs for the character map. A byte of 0xFF outside an open sequence closes the
// current glyph's list and advances the glyph counter; other bytes are UTF-8, and each
// complete character gives one result item with its code point cut to 16 bits. The
// block takes one item every cycle while req_stall is low: an accepted item is loaded
// into the input register, the decode logic behind it works out the result, and that
// result is loaded into the result register when the register is free. Only rsp_stall
// holds it back, since the input register advances whenever the result register is
// empty or being taken. Items that produce no result (end marks, lead and non-final
// continuation bytes) simply leave the pipeline.
`default_nettype none

module font_unicode_map_decoder_top (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire fumd_pkg::req_item_type req_item,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output fumd_pkg::rsp_item_type      rsp_item
);

   logic                   s1_valid_ff, s1_valid_in;
   fumd_pkg::req_item_type s1_item_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   fumd_pkg::rsp_item_type rsp_item_ff;

   logic                   out_free;
   logic                   proc_en;
   logic                   req_fire;
   fumd_pkg::dec_out_type  dout;

   // The held item moves on whenever the result register can take a new value.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign proc_en   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign req_fire  = req_valid && !req_stall;

   fumd_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .proc_en (proc_en),
      .item    (s1_item_ff),
      .dout    (dout)
   );

   // Next-state for the input and result valids.
   always_comb begin
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (proc_en) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end

      if (proc_en) begin
         rsp_valid_in = dout.emit;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Input register and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_fire) begin
         s1_item_ff <= req_item;
      end
      if (proc_en && dout.emit) begin
         rsp_item_ff <= dout.item;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/fumd_checker.sv
`default_nettype none
`include "assert_macros.svh"

module fumd_checker (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_stall,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_stall,
   input wire fumd_pkg::rsp_item_type rsp_item
);

   // A stalled result stays offered and unchanged.
   `FUMD_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid)
   `FUMD_ASSERT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall |=> $stable(rsp_item))

   // With the result register empty the input side is never held off.
   `FUMD_ASSERT(a_no_stall_empty, clock, reset, !rsp_valid |-> !req_stall)

   // Reset leaves both sides empty and ready.
   `FUMD_ASSERT_ALWAYS(a_reset_clear, clock, reset |=> !rsp_valid && !req_stall)

endmodule

bind font_unicode_map_decoder_top fumd_checker u_fumd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_item  (rsp_item)
);

`default_nettype wire

FILE: verif/font_unicode_map_decoder_top_tb.sv
`timescale 1ns / 1ps

module font_unicode_map_decoder_top_tb;

   localparam int CYCLE_LIMIT = 40000;
   localparam int HOLD_CYCLES = 200;
   localparam int RANDOM_ITEMS = 1840;
   localparam int GAP_PERCENT = 31;
   localparam int MAX_REPORTS = 40;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   fumd_pkg::req_item_type req_item = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   fumd_pkg::rsp_item_type rsp_item;

   // Idling controls for each side, and the request for a long receiver hold.
   logic feed_gaps_on = 1'b0;
   logic drain_stalls_on = 1'b0;
   int hold_requests = 0;
   int hold_served = 0;
   int hold_left = 0;

   // Predicted decoder state and the map entries still to come out.
   logic [15:0] glyph_count = '0;
   logic [20:0] partial_code = '0;
   logic [1:0] bytes_pending = '0;
   fumd_pkg::rsp_item_type pending_map_entries[$];
   fumd_pkg::rsp_item_type oldest_entry;

   logic [7:0] table_bytes[$];
   int items_sent = 0;
   int error_count = 0;
   int cycle_count = 0;

   font_unicode_map_decoder_top dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_item(req_item),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_item(rsp_item)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Runaway guard.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      if (error_count < MAX_REPORTS)
         $display("mismatch at %0t: %s: got %h, expected %h", $time, what, got, want);
      error_count++;
   endtask

   // Works out what one accepted byte does to the map and queues any entry it gives.
   task automatic predict_map_entry(input fumd_pkg::req_item_type it);
      fumd_pkg::rsp_item_type entry;
      logic emit;
      emit = 1'b0;
      entry = '0;
      if (it.table_start) begin
         glyph_count = '0;
         partial_code = '0;
         bytes_pending = '0;
      end
      if (bytes_pending != 0) begin
         // Any byte counts as a continuation while a sequence is open.
         partial_code = {partial_code[14:0],
                         it.data_byte[5:0] & fumd_pkg::MASK_CONT[5:0]};
         bytes_pending = bytes_pending - 2'd1;
         if (bytes_pending == 0) begin
            emit = 1'b1;
            entry.code_point = partial_code[15:0];
            partial_code = '0;
         end
      end else if (it.data_byte == fumd_pkg::END_MARK) begin
         glyph_count = glyph_count + 16'd1;
      end else if (!it.data_byte[7]) begin
         emit = 1'b1;
         entry.code_point = {8'h00, it.data_byte};
      end else if (!it.data_byte[5]) begin
         partial_code = {13'd0, it.data_byte & fumd_pkg::MASK_TWO};
         bytes_pending = 2'd1;
      end else if (!it.data_byte[4]) begin
         partial_code = {13'd0, it.data_byte & fumd_pkg::MASK_THREE};
         bytes_pending = 2'd2;
      end else begin
         partial_code = {13'd0, it.data_byte & fumd_pkg::MASK_FOUR};
         bytes_pending = 2'd3;
      end
      // An unfinished sequence does not survive the final byte of a table.
      if (it.last_byte && bytes_pending != 0) begin
         partial_code = '0;
         bytes_pending = '0;
      end
      if (emit) begin
         entry.glyph_index = glyph_count;
         pending_map_entries.push_back(entry);
      end
   endtask

   // Results are checked before the item of the same edge is predicted.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_map_entries.size() == 0) begin
               report_mismatch("result with nothing expected", rsp_item.code_point, 16'h0);
            end else begin
               oldest_entry = pending_map_entries.pop_front();
               if (rsp_item.code_point !== oldest_entry.code_point)
                  report_mismatch("code_point", rsp_item.code_point, oldest_entry.code_point);
               if (rsp_item.glyph_index !== oldest_entry.glyph_index)
                  report_mismatch("glyph_index", rsp_item.glyph_index,
                                  oldest_entry.glyph_index);
            end
         end
         if (req_valid && !req_stall)
            predict_map_entry(req_item);
      end
   end

   // Receiver: a requested long hold first, otherwise random stalls when enabled.
   always @(posedge clock) begin
      if (hold_requests != hold_served) begin
         hold_served <= hold_requests;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (drain_stalls_on) begin
         rsp_stall <= ($urandom_range(99) < GAP_PERCENT);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Offers one item, with optional idle cycles first, and returns once it is taken.
   task automatic send_byte(input logic [7:0] data, input logic start, input logic last);
      fumd_pkg::req_item_type it;
      it.data_byte = data;
      it.table_start = start;
      it.last_byte = last;
      while (feed_gaps_on && $urandom_range(99) < GAP_PERCENT) begin
         req_valid <= 1'b0;
         req_item <= fumd_pkg::req_item_type'($urandom);
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item <= it;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      items_sent++;
   endtask

   // Appends one character of random length and content to the table being built.
   task automatic add_random_char();
      int unsigned len;
      int unsigned pick;
      logic [7:0] lead;
      len = $urandom_range(1, 4);
      pick = $urandom_range(2);
      if (len == 1)
         lead = 8'($urandom_range(8'h7F));
      else if (len == 2)
         lead = (pick == 0) ? {3'b100, 5'($urandom)} : {3'b110, 5'($urandom)};
      else if (len == 3)
         lead = {4'b1110, 4'($urandom)};
      else if (pick == 0)
         lead = {4'b1011, 4'($urandom)};
      else if (pick == 1)
         lead = 8'($urandom_range(8'hF8, 8'hFE));
      else
         lead = {5'b11110, 3'($urandom)};
      table_bytes.push_back(lead);
      repeat (len - 1)
         table_bytes.push_back(($urandom_range(9) == 0) ? 8'($urandom)
                                                         : {2'b10, 6'($urandom)});
   endtask

   // Sends one table of random characters and end marks with a little noise mixed in.
   task automatic send_random_table();
      logic [7:0] data;
      logic start;
      logic last;
      table_bytes.delete();
      repeat ($urandom_range(1, 6)) begin
         repeat ($urandom_range(1, 3))
            add_random_char();
         table_bytes.push_back(fumd_pkg::END_MARK);
      end
      // Some tables stop in the middle of a character.
      if ($urandom_range(9) == 0)
         table_bytes.push_back({4'b1110, 4'($urandom)});
      foreach (table_bytes[i]) begin
         data = table_bytes[i];
         start = (i == 0);
         last = (i == table_bytes.size() - 1);
         if ($urandom_range(99) < 4)
            data = 8'($urandom);
         if ($urandom_range(99) < 2)
            start = ~start;
         if ($urandom_range(99) < 2)
            last = 1'b1;
         send_byte(data, start, last);
      end
   endtask

   // Single-byte characters at the extremes and an end mark.
   task automatic test_single_bytes();
      send_byte(8'h41, 1'b1, 1'b0);
      send_byte(8'h00, 1'b0, 1'b0);
      send_byte(fumd_pkg::END_MARK, 1'b0, 1'b0);
      send_byte(8'h7F, 1'b0, 1'b0);
   endtask

   // Every lead form, including the loose ones and odd continuations.
   task automatic test_sequences();
      send_byte(8'hC3, 1'b0, 1'b0);
      send_byte(8'hA9, 1'b0, 1'b0);
      // A lead in the 0x80 range and a continuation without the 10 prefix.
      send_byte(8'h9F, 1'b0, 1'b0);
      send_byte(8'h3F, 1'b0, 1'b0);
      send_byte(8'hE2, 1'b0, 1'b0);
      send_byte(8'h82, 1'b0, 1'b0);
      send_byte(8'hAC, 1'b0, 1'b0);
      // A code point above 16 bits comes out cut.
      send_byte(8'hF0, 1'b0, 1'b0);
      send_byte(8'h9F, 1'b0, 1'b0);
      send_byte(8'h98, 1'b0, 1'b0);
      send_byte(8'h80, 1'b0, 1'b0);
      // The catch-all lead, with end marks taken as continuations.
      send_byte(8'hFE, 1'b0, 1'b0);
      send_byte(fumd_pkg::END_MARK, 1'b0, 1'b0);
      send_byte(fumd_pkg::END_MARK, 1'b0, 1'b0);
      send_byte(fumd_pkg::END_MARK, 1'b0, 1'b0);
   endtask

   // Sequences cut short by the last byte of a table or by a new table.
   task automatic test_truncation();
      send_byte(8'hE2, 1'b0, 1'b0);
      send_byte(8'h82, 1'b0, 1'b1);
      send_byte(8'hF1, 1'b0, 1'b1);
      send_byte(8'hC3, 1'b1, 1'b0);
      send_byte(8'h41, 1'b1, 1'b0);
   endtask

   // Receiver holds off for a long stretch while the sender keeps offering items.
   task automatic test_backpressure();
      hold_requests++;
      repeat (40) begin
         if ($urandom_range(1))
            send_byte(8'($urandom_range(8'h7F)), 1'b0, 1'b0);
         else
            send_byte({3'b110, 5'($urandom)}, 1'b0, 1'b0);
      end
   endtask

   // Random tables in phases with idling on both sides, one phase with none at all.
   task automatic test_random_tables();
      int stop_at;
      int phase_end;
      int phase_no;
      stop_at = items_sent + RANDOM_ITEMS;
      phase_end = items_sent;
      phase_no = 0;
      while (items_sent < stop_at) begin
         if (items_sent >= phase_end) begin
            phase_no++;
            phase_end = items_sent + 250;
            if (phase_no == 3) begin
               feed_gaps_on = 1'b0;
               drain_stalls_on = 1'b0;
            end else begin
               feed_gaps_on = 1'b1;
               drain_stalls_on = 1'b1;
            end
         end
         send_random_table();
      end
   endtask

   initial begin
      repeat (5)
         @(posedge clock);
      reset <= 1'b0;
      feed_gaps_on = 1'b1;
      drain_stalls_on = 1'b1;
      test_single_bytes();
      test_sequences();
      test_truncation();
      feed_gaps_on = 1'b0;
      drain_stalls_on = 1'b0;
      test_backpressure();
      test_random_tables();
      req_valid <= 1'b0;
      while (pending_map_entries.size() != 0)
         @(posedge clock);
      repeat (8)
         @(posedge clock);
      if (error_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/fumd_pkg.sv
hw/rtl/fumd_decode.sv
hw/rtl/font_unicode_map_decoder_top.sv
hw/rtl/fumd_checker.sv
verif/font_unicode_map_decoder_top_tb.sv
